// ===== rtl/core/qwpr_pkg.sv =====
// ----------------------------------------------------------------------------
// qwpr_pkg
// Shared widths, operation codes, status codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qwpr_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST    = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             exec;
    logic             emit_entry;
    logic [IDX_W-1:0] idx;
    logic             last;
  } qwpr_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] count;
  } qwpr_stat_t;

endpackage

// ===== rtl/core/queue_with_positional_remove.sv =====
// ----------------------------------------------------------------------------
// queue_with_positional_remove
// Bounded ordered queue of signed 32-bit values with enqueue, removal at a
// 1-based position and listing of all entries.
//
// The operation arrives on the s_axis channel with its code in tuser. Each
// enqueue, remove or unknown code gives one result transaction on m_axis
// with tlast set, in the cycle after acceptance. A list of N stored entries
// gives N transactions, one per cycle while m_axis takes them, head first,
// tlast on the final one; an empty list gives one transaction with no value.
// Every result carries the count held after the operation and a status code.
// Enqueue writes the entry at the tail and removal makes a parallel shift of
// the entry registers, so such operations sustain one per cycle while m_axis
// takes each result. A list holds the input while the controller walks the
// entries through the single output register.
// Reset empties the queue and drops any pending result. When m_axis stalls,
// the output register holds its transaction and s_axis_tready falls until
// it is taken.
// ----------------------------------------------------------------------------
module queue_with_positional_remove (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[36:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[1:0], count[6:2],
                                      // entry_value[38:7], zero pad
  output logic        m_axis_tuser,   // has_value
  output logic        m_axis_tlast    // last
);
  import qwpr_pkg::*;

  qwpr_cmd_t               cmd;
  qwpr_stat_t              stat;
  logic [ST_W-1:0]         status;
  logic [COUNT_W-1:0]      count;
  logic signed [VAL_W-1:0] entry_value;

  qwpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qwpr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_op           (s_axis_tuser),
    .in_value        (s_axis_tdata[31:0]),
    .in_position     (s_axis_tdata[36:32]),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_status      (status),
    .out_count       (count),
    .out_has_value   (m_axis_tuser),
    .out_entry_value (entry_value),
    .out_last        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, entry_value, count, status};

endmodule

// ===== rtl/core/qwpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qwpr_ctrl
// Controller: accepts operations and walks the stored entries during a list.
// ----------------------------------------------------------------------------
module qwpr_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [qwpr_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  qwpr_pkg::qwpr_stat_t     stat,
  output qwpr_pkg::qwpr_cmd_t      cmd
);
  import qwpr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             list_walk;
  logic             last_entry;

  assign in_ready   = (state == S_IDLE) && stat.out_free;
  assign accept     = in_valid && in_ready;
  assign list_walk  = (in_op == OP_LIST) && (stat.count != '0);
  assign last_entry = ({1'b0, idx} + CNT_W'(1)) == stat.count;

  always_comb begin
    cmd.exec       = accept && !list_walk;
    cmd.emit_entry = (state == S_LIST) && stat.out_free;
    cmd.idx        = idx;
    cmd.last       = last_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && list_walk) begin
            state <= S_LIST;
            idx   <= '0;
          end
        end
        S_LIST: begin
          if (stat.out_free) begin
            idx <= idx + IDX_W'(1);
            if (last_entry) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/qwpr_dp.sv =====
// ----------------------------------------------------------------------------
// qwpr_dp
// Datapath: entry registers with parallel shift on removal, occupancy count
// and the output register.
// ----------------------------------------------------------------------------
module qwpr_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [qwpr_pkg::OP_W-1:0]        in_op,
  input  logic signed [qwpr_pkg::VAL_W-1:0] in_value,
  input  logic [qwpr_pkg::POS_W-1:0]       in_position,
  input  qwpr_pkg::qwpr_cmd_t              cmd,
  output qwpr_pkg::qwpr_stat_t             stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [qwpr_pkg::ST_W-1:0]        out_status,
  output logic [qwpr_pkg::COUNT_W-1:0]     out_count,
  output logic                             out_has_value,
  output logic signed [qwpr_pkg::VAL_W-1:0] out_entry_value,
  output logic                             out_last
);
  import qwpr_pkg::*;

  logic signed [VAL_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [ST_W-1:0]         status_next;
  logic                    do_enqueue;
  logic                    do_remove;
  logic                    pos_bad;

  assign pos_bad = (in_position == '0) || (CNT_W'(in_position) > count);

  always_comb begin
    do_enqueue  = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_DONE;
    count_next  = count;
    case (in_op)
      OP_ENQUEUE: begin
        if (count == CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          do_enqueue = cmd.exec;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          do_remove  = cmd.exec;
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.count    = count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_enqueue && (count[IDX_W-1:0] == IDX_W'(i))) begin
        entries[i] <= in_value;
      end else if (do_remove && (i < DEPTH - 1) &&
                   (CNT_W'(i) + CNT_W'(1) >= CNT_W'(in_position))) begin
        entries[i] <= entries[(i + 1) % DEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (cmd.emit_entry) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status      <= status_next;
      out_count       <= COUNT_W'(count_next);
      out_has_value   <= 1'b0;
      out_entry_value <= '0;
      out_last        <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_status      <= ST_DONE;
      out_count       <= COUNT_W'(count);
      out_has_value   <= 1'b1;
      out_entry_value <= entries[cmd.idx];
      out_last        <= cmd.last;
    end
  end

endmodule

// ===== sim/tb_queue_with_positional_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_queue_with_positional_remove
// Self-checking bench for the bounded queue with removal at a position.
// A short table of directed operations covers the empty and full queue, the
// signed value extremes, rejected positions and the unused operation code.
// Random traffic follows in four phases that vary idle gaps on the input
// channel and stalls on the result channel. Every result transaction is
// compared field by field against a queue model updated on each accepted
// operation.
// ----------------------------------------------------------------------------
module tb_queue_with_positional_remove;
  import qwpr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 44;
  localparam int N_DIRECTED     = 22;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
    logic               has_value;
    logic [VAL_W-1:0]   entry_value;
    logic               last;
  } queue_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   pos;
    logic [4:0]         reps;
    logic               typed;
    logic [ST_W-1:0]    exp_status;
    logic [COUNT_W-1:0] exp_count;
  } directed_op_t;

  localparam directed_op_t DIRECTED_OPS [N_DIRECTED] = '{
    '{OP_LIST,    32'h0000_0000,  5'd0, 5'd1,  1'b1, ST_DONE,  5'd0},
    '{OP_REMOVE,  32'h0000_0000,  5'd0, 5'd1,  1'b1, ST_RANGE, 5'd0},
    '{OP_REMOVE,  32'h0000_0000,  5'd1, 5'd1,  1'b1, ST_RANGE, 5'd0},
    '{OP_UNUSED,  32'hFFFF_FFFF, 5'd31, 5'd1,  1'b1, ST_DONE,  5'd0},
    '{OP_ENQUEUE, 32'h7FFF_FFFF, 5'd31, 5'd1,  1'b1, ST_DONE,  5'd1},
    '{OP_ENQUEUE, 32'h8000_0000,  5'd0, 5'd1,  1'b1, ST_DONE,  5'd2},
    '{OP_ENQUEUE, 32'hFFFF_FFFF,  5'd0, 5'd1,  1'b1, ST_DONE,  5'd3},
    '{OP_ENQUEUE, 32'h0000_0000,  5'd0, 5'd1,  1'b1, ST_DONE,  5'd4},
    '{OP_LIST,    32'h0000_0000,  5'd0, 5'd1,  1'b0, ST_DONE,  5'd0},
    '{OP_REMOVE,  32'h0000_0000,  5'd0, 5'd1,  1'b1, ST_RANGE, 5'd4},
    '{OP_REMOVE,  32'h0000_0000,  5'd5, 5'd1,  1'b1, ST_RANGE, 5'd4},
    '{OP_REMOVE,  32'hFFFF_FFFF, 5'd31, 5'd1,  1'b1, ST_RANGE, 5'd4},
    '{OP_REMOVE,  32'h0000_0000,  5'd2, 5'd1,  1'b1, ST_DONE,  5'd3},
    '{OP_LIST,    32'h0000_0000,  5'd0, 5'd1,  1'b0, ST_DONE,  5'd0},
    '{OP_REMOVE,  32'h0000_0000,  5'd3, 5'd1,  1'b1, ST_DONE,  5'd2},
    '{OP_REMOVE,  32'h0000_0000,  5'd1, 5'd1,  1'b1, ST_DONE,  5'd1},
    '{OP_ENQUEUE, 32'hA5A5_0000,  5'd0, 5'd15, 1'b0, ST_DONE,  5'd0},
    '{OP_ENQUEUE, 32'h5A5A_5A5A,  5'd0, 5'd1,  1'b1, ST_FULL,  5'd16},
    '{OP_LIST,    32'h0000_0000,  5'd0, 5'd1,  1'b0, ST_DONE,  5'd0},
    '{OP_REMOVE,  32'h0000_0000, 5'd16, 5'd1,  1'b1, ST_DONE,  5'd15},
    '{OP_REMOVE,  32'h0000_0000, 5'd16, 5'd1,  1'b1, ST_RANGE, 5'd15},
    '{OP_LIST,    32'h0000_0000,  5'd0, 5'd1,  1'b0, ST_DONE,  5'd0}
  };

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // value[31:0], position[36:32], zero pad
  logic [1:0]  s_axis_tuser  = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // status[1:0], count[6:2],
                                     // entry_value[38:7], zero pad
  logic        m_axis_tuser;         // has_value
  logic        m_axis_tlast;

  queue_with_positional_remove DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [VAL_W-1:0] model_entries [DEPTH];
  int               model_count = 0;
  queue_result_t    pending_results [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int error_count  = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int n_enqueue    = 0;
  int n_remove     = 0;
  int n_list       = 0;
  int n_unused     = 0;
  int n_full       = 0;
  int n_range      = 0;
  int peak_count   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void predict_queue_op(input logic [OP_W-1:0] op,
                                           input logic [VAL_W-1:0] val,
                                           input logic [POS_W-1:0] pos);
    queue_result_t r;
    r = '{status: ST_DONE, count: '0, has_value: 1'b0, entry_value: '0, last: 1'b1};
    case (op)
      OP_ENQUEUE: begin
        n_enqueue++;
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          model_entries[model_count] = val;
          model_count++;
          if (model_count > peak_count) peak_count = model_count;
        end
      end
      OP_REMOVE: begin
        n_remove++;
        if (pos == 0 || int'(pos) > model_count) begin
          r.status = ST_RANGE;
          n_range++;
        end else begin
          for (int i = int'(pos) - 1; i + 1 < model_count; i++)
            model_entries[i] = model_entries[i + 1];
          model_count--;
        end
      end
      OP_LIST: begin
        n_list++;
        if (model_count != 0) begin
          for (int i = 0; i < model_count; i++) begin
            r.count       = COUNT_W'(model_count);
            r.has_value   = 1'b1;
            r.entry_value = model_entries[i];
            r.last        = (i == model_count - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: n_unused++;
    endcase
    r.count = COUNT_W'(model_count);
    pending_results.push_back(r);
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                         input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, val};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_queue_op(op, val, pos);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status      = m_axis_tdata[1:0];
      got.count       = m_axis_tdata[6:2];
      got.entry_value = m_axis_tdata[38:7];
      got.has_value   = m_axis_tuser;
      got.last        = m_axis_tlast;
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display({"ERROR: unexpected result status=%0d count=%0d",
                    " has_value=%0b value=%h last=%0b"},
                   got.status, got.count, got.has_value, got.entry_value, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          error_count++;
          if (error_count <= 10)
            $display({"ERROR: result %0d expected status=%0d count=%0d",
                      " has_value=%0b value=%h last=%0b, got status=%0d",
                      " count=%0d has_value=%0b value=%h last=%0b"},
                     results_seen, want.status, want.count, want.has_value,
                     want.entry_value, want.last, got.status, got.count,
                     got.has_value, got.entry_value, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               tx_phase [4];
    int               rx_phase [4];
    int               enq_phase [4];
    int               pick;
    int               enq_pct;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    directed_op_t     row;

    tx_phase  = '{0, 65, 0, 15};
    rx_phase  = '{0, 0, 65, 15};
    enq_phase = '{55, 35, 55, 35};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED_OPS[k];
      for (int n = 0; n < int'(row.reps); n++) begin
        send_op(row.op, row.value + VAL_W'(n), row.pos);
        if (row.typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back('{status: row.exp_status, count: row.exp_count,
                                      has_value: 1'b0, entry_value: '0, last: 1'b1});
        end
      end
    end
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_phase[ph];
      rx_stall_pct = rx_phase[ph];
      enq_pct      = enq_phase[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        pos  = POS_W'($urandom_range(31));
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'h0000_0000;
            default: val = 32'hFFFF_FFFF;
          endcase
        end else begin
          val = $urandom;
        end
        if (pick < enq_pct) begin
          op = OP_ENQUEUE;
        end else if (pick < enq_pct + 12) begin
          op = OP_LIST;
        end else if (pick < enq_pct + 15) begin
          op = OP_UNUSED;
        end else if (pick < enq_pct + 21 || model_count == 0) begin
          op  = OP_REMOVE;
          pos = ($urandom_range(1) == 0) ? '0 : POS_W'($urandom_range(31, model_count + 1));
        end else begin
          op  = OP_REMOVE;
          pos = POS_W'($urandom_range(model_count, 1));
        end
        send_op(op, val, pos);
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d enqueue, %0d remove, %0d list, %0d unused code.",
             n_enqueue + n_remove + n_list + n_unused, n_enqueue, n_remove, n_list,
             n_unused);
    $display("Checked %0d results; peak fill %0d of %0d, %0d full drops, %0d bad positions.",
             results_seen, peak_count, DEPTH, n_full, n_range);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("ERROR: %0d mismatches, %0d results never arrived",
               error_count, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
